>>> rtl/q2e_pkg.sv
// Shared constants, the matrix term bundle and the arctangent table for the
// quaternion to Euler angle pipeline. No dependencies.
package q2e_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned INPUT_WIDTH       = 16;

  localparam int unsigned QW = 16;
  localparam int unsigned PW = 32;
  localparam int unsigned MW = 33;
  localparam int unsigned SW = 64;
  localparam int unsigned CYW = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CW = 36;
  localparam int unsigned AW = 34;
  localparam int unsigned OW = 16;

  localparam logic signed [MW-1:0] ONE_Q29   = 33'sd536870912;
  localparam logic signed [AW-1:0] HALF_PI   = 34'sd1686629713;
  localparam logic signed [AW-1:0] ROUND_BIT = 34'sd65536;
  localparam logic signed [AW-18:0] ANGLE_MAX = 17'sd25736;

  typedef struct packed {
    logic signed [MW-1:0] m31;
    logic signed [MW-1:0] m32;
    logic signed [MW-1:0] m33;
    logic signed [MW-1:0] m12;
    logic signed [MW-1:0] m22;
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m21;
  } mat_t;

  function automatic logic signed [AW-1:0] atan_entry(input int unsigned i);
    logic signed [AW-1:0] r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837830;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/q2e_matrix.sv
// Input register, pair products and rotation matrix terms in three stages.
// Depends on q2e_pkg.
module q2e_matrix #(
  parameter int unsigned INPUT_WIDTH = q2e_pkg::INPUT_WIDTH
) (
  input  logic                          clk_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_w_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_x_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_y_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_z_i,
  output q2e_pkg::mat_t                 mat_o
);

  localparam int unsigned QW = q2e_pkg::QW;
  localparam int unsigned PW = q2e_pkg::PW;
  localparam int unsigned MW = q2e_pkg::MW;

  logic signed [INPUT_WIDTH-1:0] raw[4];
  logic signed [QW-1:0] q15[4];
  logic signed [QW-1:0] q_q[4];

  assign raw[0] = quat_w_i;
  assign raw[1] = quat_x_i;
  assign raw[2] = quat_y_i;
  assign raw[3] = quat_z_i;

  for (genvar c = 0; c < 4; c++) begin : g_conv
    if (INPUT_WIDTH > QW) begin : g_wide
      assign q15[c] = QW'(raw[c] >>> (INPUT_WIDTH - QW));
    end else if (INPUT_WIDTH == QW) begin : g_same
      assign q15[c] = raw[c];
    end else begin : g_narrow
      assign q15[c] = {raw[c], {(QW - INPUT_WIDTH){1'b0}}};
    end
    always_ff @(posedge clk_i) begin
      q_q[c] <= q15[c];
    end
  end

  logic signed [PW-1:0] xx_q, yy_q, zz_q, xz_q, yw_q, yz_q, xw_q, xy_q, zw_q;

  always_ff @(posedge clk_i) begin
    xx_q <= q_q[1] * q_q[1];
    yy_q <= q_q[2] * q_q[2];
    zz_q <= q_q[3] * q_q[3];
    xz_q <= q_q[1] * q_q[3];
    yw_q <= q_q[2] * q_q[0];
    yz_q <= q_q[2] * q_q[3];
    xw_q <= q_q[1] * q_q[0];
    xy_q <= q_q[1] * q_q[2];
    zw_q <= q_q[3] * q_q[0];
  end

  q2e_pkg::mat_t mat_q;

  always_ff @(posedge clk_i) begin
    mat_q.m31 <= MW'(xz_q) + MW'(yw_q);
    mat_q.m32 <= MW'(yz_q) - MW'(xw_q);
    mat_q.m33 <= q2e_pkg::ONE_Q29 - MW'(xx_q) - MW'(yy_q);
    mat_q.m12 <= MW'(xy_q) + MW'(zw_q);
    mat_q.m22 <= q2e_pkg::ONE_Q29 - MW'(xx_q) - MW'(zz_q);
    mat_q.m11 <= q2e_pkg::ONE_Q29 - MW'(yy_q) - MW'(zz_q);
    mat_q.m21 <= MW'(xy_q) - MW'(zw_q);
  end

  assign mat_o = mat_q;

endmodule

>>> rtl/q2e_isqrt.sv
// Pipelined square root of m33^2 + m31^2, one result bit per stage, with the
// matrix terms carried alongside. Depends on q2e_pkg.
module q2e_isqrt (
  input  logic                        clk_i,
  input  q2e_pkg::mat_t               mat_i,
  output q2e_pkg::mat_t               mat_o,
  output logic [q2e_pkg::CYW-1:0]     cy_o
);

  localparam int unsigned MW  = q2e_pkg::MW;
  localparam int unsigned SW  = q2e_pkg::SW;
  localparam int unsigned CYW = q2e_pkg::CYW;
  localparam int unsigned NS  = q2e_pkg::SQRT_STEPS;

  logic [MW-1:0] abs31, abs33;
  logic [SW-1:0] sq31_q, sq33_q;
  q2e_pkg::mat_t mat_a_q;

  assign abs31 = mat_i.m31[MW-1] ? MW'(-mat_i.m31) : MW'(mat_i.m31);
  assign abs33 = mat_i.m33[MW-1] ? MW'(-mat_i.m33) : MW'(mat_i.m33);

  always_ff @(posedge clk_i) begin
    sq31_q  <= SW'(abs31[CYW-1:0]) * SW'(abs31[CYW-1:0]);
    sq33_q  <= SW'(abs33[CYW-1:0]) * SW'(abs33[CYW-1:0]);
    mat_a_q <= mat_i;
  end

  logic [SW-1:0] n_q[NS+1];
  logic [SW-1:0] res_q[NS+1];
  q2e_pkg::mat_t mat_q[NS+1];

  always_ff @(posedge clk_i) begin
    n_q[0]   <= sq31_q + sq33_q;
    res_q[0] <= '0;
    mat_q[0] <= mat_a_q;
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
    logic [SW-1:0] trial;
    logic          take;
    assign trial = res_q[k] + BIT;
    assign take  = n_q[k] >= trial;
    always_ff @(posedge clk_i) begin
      n_q[k+1]   <= take ? n_q[k] - trial : n_q[k];
      res_q[k+1] <= take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
      mat_q[k+1] <= mat_q[k];
    end
  end

  assign mat_o = mat_q[NS];
  assign cy_o  = res_q[NS][CYW-1:0];

endmodule

>>> rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC for atan2: quadrant stage, one stage per
// iteration, then rounding to Q3.13 with saturation. Depends on q2e_pkg.
module q2e_cordic #(
  parameter int unsigned ITERATIONS = q2e_pkg::CORDIC_ITERATIONS
) (
  input  logic                           clk_i,
  input  logic signed [q2e_pkg::CW-1:0]  y_i,
  input  logic signed [q2e_pkg::CW-1:0]  x_i,
  output logic signed [q2e_pkg::OW-1:0]  angle_o
);

  localparam int unsigned CW = q2e_pkg::CW;
  localparam int unsigned AW = q2e_pkg::AW;
  localparam int unsigned OW = q2e_pkg::OW;

  logic signed [CW-1:0] x_q[ITERATIONS+1];
  logic signed [CW-1:0] y_q[ITERATIONS+1];
  logic signed [AW-1:0] a_q[ITERATIONS+1];
  logic                 zero_q[ITERATIONS+1];

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        a_q[0] <= q2e_pkg::HALF_PI;
      end else begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        a_q[0] <= -q2e_pkg::HALF_PI;
      end
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      a_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic signed [AW-1:0] ATAN = q2e_pkg::atan_entry(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        a_q[i+1] <= a_q[i] + ATAN;
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        a_q[i+1] <= a_q[i] - ATAN;
      end
    end
  end

  logic signed [AW-1:0]  rounded;
  logic signed [AW-18:0] scaled;
  logic signed [OW-1:0]  angle_d, angle_q;

  assign rounded = a_q[ITERATIONS] + q2e_pkg::ROUND_BIT;
  assign scaled  = rounded[AW-1:17];

  always_comb begin
    if (zero_q[ITERATIONS]) begin
      angle_d = '0;
    end else if (scaled > q2e_pkg::ANGLE_MAX) begin
      angle_d = OW'(q2e_pkg::ANGLE_MAX);
    end else if (scaled < -q2e_pkg::ANGLE_MAX) begin
      angle_d = OW'(-q2e_pkg::ANGLE_MAX);
    end else begin
      angle_d = scaled[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

>>> rtl/quaternion_to_euler.sv
// Quaternion to Euler angles (y-x-z order) in a fully pipelined datapath.
// Start an item by raising start with the four Q1.15 components; busy is
// always low, so an item is taken in every cycle that start is high.
// Each result appears on angle_x_o, angle_y_o, angle_z_o and gimbal_lock_o for
// exactly one cycle, marked by valid_o. Throughput is one item per cycle.
// The datapath runs through the matrix stages, the 32 square root stages (one
// result bit each) and the CORDIC stages (one iteration each), in that order.
// The receiver cannot stall the block; results leave as they finish.
// lock_threshold_i is written when lock_threshold_we_i is high and is used
// for items in flight, so write it only while the pipeline is empty.
// Reset clears the valid line and the threshold; payload in flight is lost.
// Depends on q2e_pkg, q2e_matrix, q2e_isqrt and q2e_cordic.
module quaternion_to_euler #(
  parameter int unsigned CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITERATIONS,
  parameter int unsigned INPUT_WIDTH       = q2e_pkg::INPUT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [INPUT_WIDTH-1:0] quat_w_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_x_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_y_i,
  input  logic signed [INPUT_WIDTH-1:0] quat_z_i,
  input  logic                          lock_threshold_we_i,
  input  logic [15:0]                   lock_threshold_i,
  output logic                          valid_o,
  output logic signed [15:0]            angle_x_o,
  output logic signed [15:0]            angle_y_o,
  output logic signed [15:0]            angle_z_o,
  output logic                          gimbal_lock_o
);

  localparam int unsigned CW  = q2e_pkg::CW;
  localparam int unsigned CYW = q2e_pkg::CYW;
  localparam int unsigned CL  = CORDIC_ITERATIONS + 2;
  localparam int unsigned LAT = 3 + (q2e_pkg::SQRT_STEPS + 2) + 1 + CL;

  logic [15:0]    thr_q;
  logic [LAT-1:0] v_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      v_q   <= '0;
    end else begin
      if (lock_threshold_we_i) begin
        thr_q <= lock_threshold_i;
      end
      v_q <= {v_q[LAT-2:0], start};
    end
  end

  q2e_pkg::mat_t mat_m, mat_s;
  logic [CYW-1:0] cy;

  q2e_matrix #(.INPUT_WIDTH(INPUT_WIDTH)) u_matrix (
    .clk_i    (clk_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .mat_o    (mat_m)
  );

  q2e_isqrt u_isqrt (
    .clk_i (clk_i),
    .mat_i (mat_m),
    .mat_o (mat_s),
    .cy_o  (cy)
  );

  logic                 lock_d;
  logic signed [CW-1:0] xy_q, xx_q, yy_q, yx_q, zy_q, zx_q;
  logic [CL:0]          lk_q;

  assign lock_d = !(cy > {1'b0, thr_q, 15'b0});

  always_ff @(posedge clk_i) begin
    xy_q <= -CW'(mat_s.m32);
    xx_q <= $signed({{(CW - CYW){1'b0}}, cy});
    yy_q <= CW'(mat_s.m31);
    yx_q <= CW'(mat_s.m33);
    if (lock_d) begin
      zy_q <= -CW'(mat_s.m21);
      zx_q <= CW'(mat_s.m11);
    end else begin
      zy_q <= CW'(mat_s.m12);
      zx_q <= CW'(mat_s.m22);
    end
    lk_q <= {lk_q[CL-1:0], lock_d};
  end

  logic signed [15:0] ax, ay, az;

  q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_x (
    .clk_i (clk_i), .y_i (xy_q), .x_i (xx_q), .angle_o (ax)
  );

  q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_y (
    .clk_i (clk_i), .y_i (yy_q), .x_i (yx_q), .angle_o (ay)
  );

  q2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_z (
    .clk_i (clk_i), .y_i (zy_q), .x_i (zx_q), .angle_o (az)
  );

  assign valid_o       = v_q[LAT-1];
  assign angle_x_o     = ax;
  assign angle_y_o     = lk_q[CL] ? 16'sd0 : ay;
  assign angle_z_o     = az;
  assign gimbal_lock_o = lk_q[CL];

endmodule
